// ----- hdl/quasi_bidir_port_arbiter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// quasi_bidir_port_arbiter_unit_assert.svh
// assertion macros used by the port arbiter back end
// ----------------------------------------------------------------------------
`ifndef QUASI_BIDIR_PORT_ARBITER_UNIT_ASSERT_SVH
`define QUASI_BIDIR_PORT_ARBITER_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define QBPA_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// condition in one cycle implies another in the next cycle
`define QBPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// qbpa_pkg
// types, codes and helpers of the quasi-bidirectional port arbiter
// ----------------------------------------------------------------------------
package qbpa_pkg;

  // access codes
  typedef enum logic [2:0] {
    ACT_PORT_LATCH_RD = 3'd0,
    ACT_BIT_LATCH_RD  = 3'd1,
    ACT_BIT_PIN_RD    = 3'd2,
    ACT_PORT_PIN_RD   = 3'd3,
    ACT_BIT_WR        = 3'd4,
    ACT_PORT_WR       = 3'd5,
    ACT_CLR_CNT       = 3'd6
  } qbpa_action_e;

  // pin event codes
  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_DRIVEN     = 2'd1,
    EV_SUPPRESSED = 2'd2
  } qbpa_event_e;

  localparam logic [7:0]  LATCH_RST = 8'hFF;
  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

  // one classified access handed from front to back
  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  port;
    logic [7:0]  diff;
    logic [7:0]  level;
    logic [7:0]  allow;
    logic [7:0]  wtrap;
    logic [31:0] sup_cnt;
    logic [31:0] ana_cnt;
  } qbpa_entry_t;

  // saturating add of a small increment
  function automatic logic [31:0] sat_add(input logic [31:0] cnt, input logic [3:0] inc);
    logic [32:0] sum;
    sum = {1'b0, cnt} + {29'd0, inc};
    return sum[32] ? CNT_MAX : sum[31:0];
  endfunction

endpackage

// ----- hdl/qbpa_if.sv -----
// ----------------------------------------------------------------------------
// qbpa_if
// valid/ready channels for accesses and results of the port arbiter
// ----------------------------------------------------------------------------
interface qbpa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] port;
  logic [2:0] bit_index;
  logic [7:0] write_value;
  logic [7:0] analog_mask;
  logic [7:0] read_trap_mask;
  logic [7:0] read_trap_level;
  logic [7:0] ext_valid_mask;
  logic [7:0] ext_level;
  logic [7:0] pullup_mask;
  logic [7:0] drive_allow_mask;
  logic [7:0] write_trap_mask;

  modport source (
    output valid, action, port, bit_index, write_value, analog_mask, read_trap_mask,
           read_trap_level, ext_valid_mask, ext_level, pullup_mask, drive_allow_mask,
           write_trap_mask,
    input  ready
  );
  modport sink (
    input  valid, action, port, bit_index, write_value, analog_mask, read_trap_mask,
           read_trap_level, ext_valid_mask, ext_level, pullup_mask, drive_allow_mask,
           write_trap_mask,
    output ready
  );
endinterface

interface qbpa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  event_kind;
  logic [4:0]  pin_key;
  logic        pin_value;
  logic        drive_weak;
  logic        write_trap_fire;
  logic        last;
  logic [31:0] suppressed_count;
  logic [31:0] analog_read_count;
  logic [31:0] diag_total;

  modport source (
    output valid, read_data, event_kind, pin_key, pin_value, drive_weak, write_trap_fire,
           last, suppressed_count, analog_read_count, diag_total,
    input  ready
  );
  modport sink (
    input  valid, read_data, event_kind, pin_key, pin_value, drive_weak, write_trap_fire,
           last, suppressed_count, analog_read_count, diag_total,
    output ready
  );
endinterface

// ----- hdl/qbpa_front.sv -----
// ----------------------------------------------------------------------------
// qbpa_front
// accepts accesses, resolves reads, updates port latches and counters
// ----------------------------------------------------------------------------
module qbpa_front #(
  parameter int NUM_PORTS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  enh_i,
  qbpa_in_if.sink               req,
  output logic                  push_o,
  input  logic                  push_ready_i,
  output qbpa_pkg::qbpa_entry_t entry_o
);
  import qbpa_pkg::*;

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [7:0]   latch_q [NUM_PORTS];
  logic [31:0]  sup_q, sup_d;
  logic [31:0]  ana_q, ana_d;

  logic         accept;
  logic         ok;
  logic [PW-1:0] idx;
  logic [7:0]   latch;
  logic [7:0]   ana, pu, pin, allow;
  logic [7:0]   rd_raw, new_latch, diff;
  logic [3:0]   ana_inc, sup_inc;
  logic         wr, clr;
  qbpa_action_e act;

  assign accept    = req.valid && req.ready;
  assign req.ready = push_ready_i;
  assign push_o    = accept;

  // address decode
  assign ok    = ({1'b0, req.port} < 4'(NUM_PORTS));
  assign idx   = req.port[PW-1:0];
  assign latch = ok ? latch_q[idx] : 8'h00;
  assign act   = qbpa_action_e'(req.action);

  // per pin level: analog, read trap, external, pull-up, latch
  assign ana   = (enh_i && ok) ? req.analog_mask : 8'h00;
  assign pu    = enh_i ? req.pullup_mask : 8'h00;
  assign allow = enh_i ? req.drive_allow_mask : 8'hFF;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (ana[i]) begin
        pin[i] = latch[i];
      end else if (req.read_trap_mask[i]) begin
        pin[i] = req.read_trap_level[i];
      end else if (req.ext_valid_mask[i]) begin
        pin[i] = req.ext_level[i];
      end else if (pu[i]) begin
        pin[i] = 1'b1;
      end else begin
        pin[i] = latch[i];
      end
    end
  end

  // access decode
  always_comb begin
    rd_raw    = 8'h00;
    new_latch = latch;
    ana_inc   = 4'd0;
    wr        = 1'b0;
    clr       = 1'b0;
    case (act)
      ACT_PORT_LATCH_RD: rd_raw = latch;
      ACT_BIT_LATCH_RD:  rd_raw = {7'd0, latch[req.bit_index]};
      ACT_BIT_PIN_RD: begin
        rd_raw  = {7'd0, pin[req.bit_index]};
        ana_inc = {3'd0, ana[req.bit_index]};
      end
      ACT_PORT_PIN_RD: begin
        rd_raw  = pin;
        ana_inc = 4'($countones(ana));
      end
      ACT_BIT_WR: begin
        new_latch[req.bit_index] = |req.write_value;
        wr = ok;
      end
      ACT_PORT_WR: begin
        new_latch = req.write_value;
        wr = ok;
      end
      ACT_CLR_CNT: clr = 1'b1;
      default: ;
    endcase
  end

  assign diff    = wr ? (latch ^ new_latch) : 8'h00;
  assign sup_inc = 4'($countones(diff & ~allow));

  // counters after this access
  assign sup_d = clr ? 32'd0 : sat_add(sup_q, sup_inc);
  assign ana_d = clr ? 32'd0 : sat_add(ana_q, ana_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sup_q <= 32'd0;
      ana_q <= 32'd0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        latch_q[i] <= LATCH_RST;
      end
    end else if (accept) begin
      sup_q <= sup_d;
      ana_q <= ana_d;
      if (wr) begin
        latch_q[idx] <= new_latch;
      end
    end
  end

  // queue entry
  always_comb begin
    entry_o.read_data = ok ? rd_raw : 8'h00;
    entry_o.port      = req.port;
    entry_o.diff      = diff;
    entry_o.level     = new_latch;
    entry_o.allow     = allow;
    entry_o.wtrap     = req.write_trap_mask;
    entry_o.sup_cnt   = sup_d;
    entry_o.ana_cnt   = ana_d;
  end

endmodule

// ----- hdl/qbpa_queue.sv -----
// ----------------------------------------------------------------------------
// qbpa_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module qbpa_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  qbpa_pkg::qbpa_entry_t push_data_i,
  output logic                  push_ready_o,
  input  logic                  pop_i,
  output qbpa_pkg::qbpa_entry_t head_o,
  output logic                  head_valid_o
);
  import qbpa_pkg::*;

  qbpa_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/qbpa_back.sv -----
// ----------------------------------------------------------------------------
// qbpa_back
// expands each access into result beats: one per changed pin, else one beat
// ----------------------------------------------------------------------------
`include "quasi_bidir_port_arbiter_unit_assert.svh"

module qbpa_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qbpa_pkg::qbpa_entry_t head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  qbpa_out_if.source            rsp
);
  import qbpa_pkg::*;

  logic [7:0]  sent_q, sent_d;
  logic [7:0]  rem, low;
  logic [2:0]  bidx;
  logic        is_last, load;

  logic        ov_q;
  logic [7:0]  rd_q;
  qbpa_event_e ev_q, ev_d;
  logic [4:0]  key_q, key_d;
  logic        lvl_q, lvl_d, weak_q, weak_d, wtf_q, wtf_d, last_q;
  logic [31:0] sup_q, ana_q, tot_q;

  // lowest pin not yet reported
  assign rem     = head_i.diff & ~sent_q;
  assign low     = rem & (~rem + 8'd1);
  assign is_last = ((rem & ~low) == 8'h00);

  always_comb begin
    bidx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (low[i]) begin
        bidx = 3'(i);
      end
    end
  end

  assign load  = head_valid_i && (!ov_q || rsp.ready);
  assign pop_o = load && is_last;

  always_comb begin
    sent_d = sent_q;
    if (load) begin
      sent_d = is_last ? 8'h00 : (sent_q | low);
    end
  end

  // event fields of the next beat
  always_comb begin
    ev_d   = EV_NONE;
    key_d  = 5'd0;
    lvl_d  = 1'b0;
    weak_d = 1'b0;
    wtf_d  = 1'b0;
    if (low != 8'h00) begin
      key_d = {head_i.port[1:0], bidx};
      lvl_d = head_i.level[bidx];
      wtf_d = head_i.wtrap[bidx];
      if (head_i.allow[bidx]) begin
        ev_d   = EV_DRIVEN;
        weak_d = head_i.level[bidx];
      end else begin
        ev_d   = EV_SUPPRESSED;
      end
    end
  end

  // output valid and progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sent_q <= 8'h00;
    end else begin
      sent_q <= sent_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (rsp.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_q   <= head_i.read_data;
      ev_q   <= ev_d;
      key_q  <= key_d;
      lvl_q  <= lvl_d;
      weak_q <= weak_d;
      wtf_q  <= wtf_d;
      last_q <= is_last;
      sup_q  <= head_i.sup_cnt;
      ana_q  <= head_i.ana_cnt;
      tot_q  <= head_i.sup_cnt + head_i.ana_cnt;
    end
  end

  assign rsp.valid             = ov_q;
  assign rsp.read_data         = rd_q;
  assign rsp.event_kind        = ev_q;
  assign rsp.pin_key           = key_q;
  assign rsp.pin_value         = lvl_q;
  assign rsp.drive_weak        = weak_q;
  assign rsp.write_trap_fire   = wtf_q;
  assign rsp.last              = last_q;
  assign rsp.suppressed_count  = sup_q;
  assign rsp.analog_read_count = ana_q;
  assign rsp.diag_total        = tot_q;

  `QBPA_ASSERT(a_sent_in_diff, !head_valid_i || ((sent_q & ~head_i.diff) == 8'h00), "reported pin outside the changed set")
  `QBPA_ASSERT(a_sent_needs_head, (sent_q == 8'h00) || head_valid_i, "pin progress left without a pending access")
  `QBPA_ASSERT(a_none_is_last, !(ov_q && (ev_q == EV_NONE)) || last_q, "beat without pin event is not the final beat")
  `QBPA_ASSERT_NEXT(a_last_clears, load && is_last, sent_q == 8'h00, "pin progress not cleared after final beat")

endmodule

// ----- hdl/quasi_bidir_port_arbiter_unit.sv -----
// ----------------------------------------------------------------------------
// quasi_bidir_port_arbiter_unit
// quasi-bidirectional gpio port block with latches and diagnostic counters
// ----------------------------------------------------------------------------
// An access is taken in any cycle in which the two-entry queue has room; its
// beats are registered in the back end. While the result channel is ready,
// reads, counter clears, unchanged writes and writes to absent ports give one
// beat and run at one access per clock, and a port write that changes k pins
// gives k beats, lowest pin first, one per clock; the back end expansion stage
// sets this figure and the front end stalls once the queue fills behind it.
// Latches and counters are updated at acceptance, and every beat carries the
// counter values after its access. enhanced_io is a plain register that the
// user must write only with the block idle; the block does not enforce this.
module quasi_bidir_port_arbiter_unit #(
  parameter int NUM_PORTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  qbpa_in_if.sink    req_i,
  qbpa_out_if.source rsp_o
);
  import qbpa_pkg::*;

  logic        enh_q;
  logic        push, push_ready, pop, head_valid;
  qbpa_entry_t push_data, head;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enh_q <= 1'b0;
    end else if (cfg_we_i) begin
      enh_q <= cfg_wdata_i;
    end
  end

  // front end: accept and classify
  qbpa_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enh_i        (enh_q),
    .req          (req_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (push_data)
  );

  // queue between the two halves
  qbpa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // back end: result beats
  qbpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .rsp          (rsp_o)
  );

endmodule

// ----- bench/tb_quasi_bidir_port_arbiter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_quasi_bidir_port_arbiter_unit
// self-checking bench for the quasi-bidirectional port block: latch and pin
// reads, bit and port writes with pin events, counter clears and invalid ports
// are sent in classic and enhanced io modes, and every result beat is checked
// against a behavioral predictor under random idling and a long sink stall
// ----------------------------------------------------------------------------
module tb_quasi_bidir_port_arbiter_unit;
  import qbpa_pkg::*;

  localparam int NUM_PORTS = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // one access as offered on the request channel
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] port;
    logic [2:0] bit_index;
    logic [7:0] write_value;
    logic [7:0] analog_mask;
    logic [7:0] read_trap_mask;
    logic [7:0] read_trap_level;
    logic [7:0] ext_valid_mask;
    logic [7:0] ext_level;
    logic [7:0] pullup_mask;
    logic [7:0] drive_allow_mask;
    logic [7:0] write_trap_mask;
  } access_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  read_data;
    qbpa_event_e event_kind;
    logic [4:0]  pin_key;
    logic        pin_value;
    logic        drive_weak;
    logic        write_trap_fire;
    logic        last;
    logic [31:0] suppressed_count;
    logic [31:0] analog_read_count;
    logic [31:0] diag_total;
  } beat_t;

  // predicted port state and the result beats still owed by the block
  class port_access_scoreboard;
    logic [7:0]  latches [NUM_PORTS];
    logic [31:0] sup_cnt;
    logic [31:0] ana_cnt;
    bit          enhanced;
    beat_t       expected_beats [$];
    int          errors;
    int          beats_seen;

    function void clear_state();
      foreach (latches[i]) latches[i] = LATCH_RST;
      sup_cnt = '0;
      ana_cnt = '0;
      enhanced = 1'b0;
      expected_beats.delete();
      errors = 0;
      beats_seen = 0;
    endfunction

    function void set_enhanced(bit on);
      enhanced = on;
    endfunction

    // level seen by a pin read, in order of priority
    function logic resolve_pin(access_t a, int p, int b);
      if (enhanced && a.analog_mask[b]) begin
        if (ana_cnt != CNT_MAX) ana_cnt++;
        return latches[p][b];
      end
      if (a.read_trap_mask[b]) return a.read_trap_level[b];
      if (a.ext_valid_mask[b]) return a.ext_level[b];
      if (enhanced && a.pullup_mask[b]) return 1'b1;
      return latches[p][b];
    endfunction

    // event beat for one changed pin
    function beat_t pin_event(access_t a, int p, int b, logic lvl);
      beat_t bt;
      bt = '0;
      if (!enhanced || a.drive_allow_mask[b]) begin
        bt.event_kind = EV_DRIVEN;
        bt.drive_weak = lvl;
      end else begin
        bt.event_kind = EV_SUPPRESSED;
        if (sup_cnt != CNT_MAX) sup_cnt++;
      end
      bt.pin_key = 5'(p * 8 + b);
      bt.pin_value = lvl;
      bt.write_trap_fire = a.write_trap_mask[b];
      return bt;
    endfunction

    function void note_access(access_t a);
      beat_t      run [$];
      beat_t      bt;
      logic [7:0] rd;
      logic [7:0] diff;
      logic       lvl;
      int         p;
      int         b;
      bit         ok;
      p = a.port;
      b = a.bit_index;
      ok = p < NUM_PORTS;
      rd = '0;
      case (a.action)
        ACT_PORT_LATCH_RD: if (ok) rd = latches[p];
        ACT_BIT_LATCH_RD:  if (ok) rd = {7'd0, latches[p][b]};
        ACT_BIT_PIN_RD:    if (ok) rd = {7'd0, resolve_pin(a, p, b)};
        ACT_PORT_PIN_RD: begin
          if (ok) for (int i = 0; i < 8; i++) rd[i] = resolve_pin(a, p, i);
        end
        ACT_BIT_WR: begin
          if (ok) begin
            lvl = a.write_value != 8'd0;
            if (latches[p][b] != lvl) run.push_back(pin_event(a, p, b, lvl));
            latches[p][b] = lvl;
          end
        end
        ACT_PORT_WR: begin
          if (ok) begin
            diff = latches[p] ^ a.write_value;
            latches[p] = a.write_value;
            for (int i = 0; i < 8; i++)
              if (diff[i]) run.push_back(pin_event(a, p, i, a.write_value[i]));
          end
        end
        ACT_CLR_CNT: begin
          sup_cnt = '0;
          ana_cnt = '0;
        end
        default: ;
      endcase
      if (run.size() == 0) begin
        bt = '0;
        bt.read_data = rd;
        run.push_back(bt);
      end
      // counters as they stand after the whole access
      foreach (run[k]) begin
        run[k].last = (k == run.size() - 1);
        run[k].suppressed_count = sup_cnt;
        run[k].analog_read_count = ana_cnt;
        run[k].diag_total = sup_cnt + ana_cnt;
        expected_beats.push_back(run[k]);
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_beat(beat_t act);
      beat_t ex;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected beat, expected none actual %0h", $time, act);
        return;
      end
      ex = expected_beats.pop_front();
      compare_field("read_data", ex.read_data, act.read_data);
      compare_field("event_kind", ex.event_kind, act.event_kind);
      compare_field("pin_key", ex.pin_key, act.pin_key);
      compare_field("pin_value", ex.pin_value, act.pin_value);
      compare_field("drive_weak", ex.drive_weak, act.drive_weak);
      compare_field("write_trap_fire", ex.write_trap_fire, act.write_trap_fire);
      compare_field("last", ex.last, act.last);
      compare_field("suppressed_count", ex.suppressed_count, act.suppressed_count);
      compare_field("analog_read_count", ex.analog_read_count, act.analog_read_count);
      compare_field("diag_total", ex.diag_total, act.diag_total);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  qbpa_in_if  req_if ();
  qbpa_out_if rsp_if ();

  port_access_scoreboard board;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  bit held_once;
  int cycle_cnt;

  quasi_bidir_port_arbiter_unit #(
    .NUM_PORTS(NUM_PORTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_quasi_bidir_port_arbiter_unit: errors");
      $finish;
    end
  end

  // sink: random stalls plus one long hold-off once results are flowing
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else if (!held_once && board.beats_seen >= 150) begin
      held_once = 1'b1;
      hold_left = 300;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = $urandom_range(99) >= snk_idle_pct;
    end
  end

  // accepted accesses feed the predictor, accepted beats are checked
  always @(posedge clk_i) begin
    access_t a;
    beat_t   bt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        a.action = req_if.action;
        a.port = req_if.port;
        a.bit_index = req_if.bit_index;
        a.write_value = req_if.write_value;
        a.analog_mask = req_if.analog_mask;
        a.read_trap_mask = req_if.read_trap_mask;
        a.read_trap_level = req_if.read_trap_level;
        a.ext_valid_mask = req_if.ext_valid_mask;
        a.ext_level = req_if.ext_level;
        a.pullup_mask = req_if.pullup_mask;
        a.drive_allow_mask = req_if.drive_allow_mask;
        a.write_trap_mask = req_if.write_trap_mask;
        board.note_access(a);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        bt.read_data = rsp_if.read_data;
        bt.event_kind = qbpa_event_e'(rsp_if.event_kind);
        bt.pin_key = rsp_if.pin_key;
        bt.pin_value = rsp_if.pin_value;
        bt.drive_weak = rsp_if.drive_weak;
        bt.write_trap_fire = rsp_if.write_trap_fire;
        bt.last = rsp_if.last;
        bt.suppressed_count = rsp_if.suppressed_count;
        bt.analog_read_count = rsp_if.analog_read_count;
        bt.diag_total = rsp_if.diag_total;
        board.check_beat(bt);
      end
    end
  end

  // offer one access, with random idle cycles ahead of it
  task automatic send_access(access_t a);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
    end
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.action = a.action;
    req_if.port = a.port;
    req_if.bit_index = a.bit_index;
    req_if.write_value = a.write_value;
    req_if.analog_mask = a.analog_mask;
    req_if.read_trap_mask = a.read_trap_mask;
    req_if.read_trap_level = a.read_trap_level;
    req_if.ext_valid_mask = a.ext_valid_mask;
    req_if.ext_level = a.ext_level;
    req_if.pullup_mask = a.pullup_mask;
    req_if.drive_allow_mask = a.drive_allow_mask;
    req_if.write_trap_mask = a.write_trap_mask;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop offering and wait for every owed beat, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(logic on);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = on;
    @(posedge clk_i);
    board.set_enhanced(on);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic access_t mk(logic [2:0] act, logic [2:0] p, logic [2:0] b,
                                 logic [7:0] wv);
    access_t a;
    a = '0;
    a.action = act;
    a.port = p;
    a.bit_index = b;
    a.write_value = wv;
    return a;
  endfunction

  // mask with extra weight on all-zero and all-one
  function automatic logic [7:0] rand_mask();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int r;
    r = $urandom_range(99);
    if (r < 22)      a.action = ACT_PORT_WR;
    else if (r < 37) a.action = ACT_BIT_WR;
    else if (r < 55) a.action = ACT_PORT_PIN_RD;
    else if (r < 70) a.action = ACT_BIT_PIN_RD;
    else if (r < 80) a.action = ACT_PORT_LATCH_RD;
    else if (r < 90) a.action = ACT_BIT_LATCH_RD;
    else if (r < 95) a.action = ACT_CLR_CNT;
    else             a.action = ACT_UNUSED;
    a.port = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    a.bit_index = 3'($urandom_range(7));
    a.write_value = (a.action == ACT_BIT_WR && $urandom_range(1)) ? 8'h00 : rand_mask();
    a.analog_mask = rand_mask();
    a.read_trap_mask = rand_mask();
    a.read_trap_level = rand_mask();
    a.ext_valid_mask = rand_mask();
    a.ext_level = rand_mask();
    a.pullup_mask = rand_mask();
    a.drive_allow_mask = rand_mask();
    a.write_trap_mask = rand_mask();
    return a;
  endfunction

  // classic mode: enhanced masks must have no effect
  task automatic directed_classic();
    access_t a;
    send_access(mk(ACT_PORT_LATCH_RD, 3'd0, 3'd0, 8'h00));
    send_access(mk(ACT_BIT_LATCH_RD, 3'd3, 3'd7, 8'h00));
    a = mk(ACT_PORT_PIN_RD, 3'd1, 3'd0, 8'h00);
    a.analog_mask = 8'hFF;
    a.pullup_mask = 8'hFF;
    a.read_trap_mask = 8'h0F;
    a.read_trap_level = 8'h05;
    a.ext_valid_mask = 8'h30;
    a.ext_level = 8'h10;
    send_access(a);
    a = mk(ACT_BIT_PIN_RD, 3'd2, 3'd0, 8'h00);
    a.analog_mask = 8'h01;
    send_access(a);
    // all eight pins change
    a = mk(ACT_PORT_WR, 3'd0, 3'd0, 8'h00);
    a.write_trap_mask = 8'hAA;
    send_access(a);
    send_access(mk(ACT_PORT_WR, 3'd0, 3'd0, 8'h00));
    send_access(mk(ACT_BIT_WR, 3'd0, 3'd3, 8'h80));
    send_access(mk(ACT_BIT_WR, 3'd0, 3'd3, 8'h01));
    // absent ports, then an unused action code and a counter clear
    send_access(mk(ACT_PORT_LATCH_RD, 3'd4, 3'd0, 8'h00));
    a = mk(ACT_PORT_PIN_RD, 3'd7, 3'd7, 8'h00);
    a.read_trap_mask = 8'hFF;
    a.read_trap_level = 8'hFF;
    send_access(a);
    send_access(mk(ACT_PORT_WR, 3'd5, 3'd0, 8'h12));
    send_access(mk(ACT_BIT_WR, 3'd6, 3'd2, 8'hFF));
    send_access(mk(ACT_UNUSED, 3'd0, 3'd0, 8'hFF));
    send_access(mk(ACT_CLR_CNT, 3'd0, 3'd0, 8'h00));
  endtask

  // enhanced mode: analog, pull-up and drive permission take effect
  task automatic directed_enhanced();
    access_t a;
    a = mk(ACT_PORT_WR, 3'd2, 3'd0, 8'h5A);
    a.drive_allow_mask = 8'hF0;
    a.write_trap_mask = 8'h3C;
    send_access(a);
    a = mk(ACT_PORT_PIN_RD, 3'd2, 3'd0, 8'h00);
    a.analog_mask = 8'h81;
    a.read_trap_mask = 8'h42;
    a.read_trap_level = 8'h40;
    a.ext_valid_mask = 8'h24;
    a.ext_level = 8'h04;
    a.pullup_mask = 8'h18;
    send_access(a);
    a = mk(ACT_BIT_PIN_RD, 3'd2, 3'd0, 8'h00);
    a.analog_mask = 8'h01;
    a.read_trap_mask = 8'h01;
    a.read_trap_level = 8'h01;
    send_access(a);
    a = mk(ACT_BIT_WR, 3'd2, 3'd0, 8'hFF);
    a.write_trap_mask = 8'h01;
    send_access(a);
    a = mk(ACT_PORT_WR, 3'd3, 3'd0, 8'h00);
    a.drive_allow_mask = 8'hFF;
    a.write_trap_mask = 8'hFF;
    send_access(a);
    send_access(mk(ACT_PORT_LATCH_RD, 3'd2, 3'd0, 8'h00));
    send_access(mk(ACT_BIT_LATCH_RD, 3'd2, 3'd6, 8'h00));
    a = mk(ACT_PORT_PIN_RD, 3'd4, 3'd0, 8'h00);
    a.analog_mask = 8'hFF;
    send_access(a);
    send_access(mk(ACT_CLR_CNT, 3'd7, 3'd7, 8'hFF));
    send_access(mk(ACT_UNUSED, 3'd3, 3'd5, 8'h00));
  endtask

  task automatic random_phase(int count, int idle_pct);
    src_idle_pct = idle_pct;
    snk_idle_pct = idle_pct;
    repeat (count) send_access(rand_access());
  endtask

  // main sequence
  initial begin
    board = new();
    board.clear_state();
    cycle_cnt = 0;
    hold_left = 0;
    held_once = 1'b0;
    src_idle_pct = 22;
    snk_idle_pct = 22;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.port = '0;
    req_if.bit_index = '0;
    req_if.write_value = '0;
    req_if.analog_mask = '0;
    req_if.read_trap_mask = '0;
    req_if.read_trap_level = '0;
    req_if.ext_valid_mask = '0;
    req_if.ext_level = '0;
    req_if.pullup_mask = '0;
    req_if.drive_allow_mask = '0;
    req_if.write_trap_mask = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b0);
    directed_classic();
    drain();
    write_mode(1'b1);
    directed_enhanced();
    drain();
    random_phase(100, 22);
    drain();
    write_mode(1'b0);
    random_phase(100, 0);
    drain();
    write_mode(1'b1);
    random_phase(100, 22);
    drain();
    repeat (10) @(posedge clk_i);

    if (board.errors == 0 && board.expected_beats.size() == 0) begin
      $display("tb_quasi_bidir_port_arbiter_unit: clean");
    end else begin
      $display("tb_quasi_bidir_port_arbiter_unit: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/qbpa_pkg.sv
hdl/qbpa_if.sv
hdl/qbpa_front.sv
hdl/qbpa_queue.sv
hdl/qbpa_back.sv
hdl/quasi_bidir_port_arbiter_unit.sv
bench/tb_quasi_bidir_port_arbiter_unit.sv
